[hdl/wdr_pkg.sv]
// ----------------------------------------------------------------------------
// wdr_pkg
// shared constants, types and tables of the dead-reckoning block
// ----------------------------------------------------------------------------
package wdr_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int STEP_W = $clog2(ATAN_LEN + 1);
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [15:0] RADIUS_RESET = 16'd7537;
	localparam logic [29:0] BAM_PER_RAD = 30'd683565276;

	typedef enum logic [1:0] {
		OP_WHEEL = 2'd0,
		OP_IMU   = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// multiplier request / result between sequencer and serial multiplier
	typedef struct packed {
		logic               start;
		logic signed [47:0] a;
		logic [31:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [79:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] angle;
	} cor_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] c;
		logic signed [15:0] s;
	} cor_rsp_t;

	function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/wdr_mul.sv]
// ----------------------------------------------------------------------------
// wdr_mul
// signed shift-add multiplier, two multiplier bits per cycle
// ----------------------------------------------------------------------------
module wdr_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  wdr_pkg::mul_req_t req,
	output wdr_pkg::mul_rsp_t rsp
);

	logic signed [79:0] acc_q;
	logic signed [79:0] mcand_q;
	logic [31:0]        mplier_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic signed [79:0] add0;
	logic signed [79:0] add1;

	always_comb begin
		add0 = mplier_q[0] ? mcand_q : 80'sd0;
		add1 = mplier_q[1] ? (mcand_q <<< 1) : 80'sd0;
		// top multiplier bit carries negative weight
		if (cnt_q == 5'd15) add1 = -add1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= 80'(req.a);
			mplier_q <= req.b;
		end else if (busy_q) begin
			acc_q    <= acc_q + add0 + add1;
			mcand_q  <= mcand_q <<< 2;
			mplier_q <= mplier_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

[hdl/wdr_cordic.sv]
// ----------------------------------------------------------------------------
// wdr_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module wdr_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  wdr_pkg::cor_req_t req,
	output wdr_pkg::cor_rsp_t rsp
);

	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [33:0] z_q;
	logic               flip_q;
	logic [wdr_pkg::STEP_W-1:0] i_q;
	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic signed [15:0] c_q;
	logic signed [15:0] s_q;
	logic [31:0]        a_fold;
	logic               fold;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [33:0] at;
	logic signed [33:0] xf;
	logic signed [33:0] yf;
	logic signed [15:0] xr;
	logic signed [15:0] yr;

	function automatic logic signed [15:0] rnd(input logic signed [33:0] v);
		logic [33:0] m;
		logic [19:0] q;
		logic signed [20:0] r;
		m = v[33] ? 34'(-v) : 34'(v);
		q = 20'((m + 34'd16384) >> 15);
		r = v[33] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (r > 21'sd32767) return 16'sd32767;
		if (r < -21'sd32768) return -16'sd32768;
		return 16'(r);
	endfunction

	always_comb begin
		fold   = (req.angle - 32'h4000_0000) < 32'h8000_0000;
		a_fold = fold ? req.angle + 32'h8000_0000 : req.angle;
		dx     = y_q >>> i_q;
		dy     = x_q >>> i_q;
		at     = $signed({2'b00, wdr_pkg::atan_bam(i_q)});
		xf     = flip_q ? -x_q : x_q;
		yf     = flip_q ? -y_q : y_q;
		xr     = rnd(xf);
		yr     = rnd(yf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (32'(i_q) == wdr_pkg::CORDIC_STEPS - 1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= wdr_pkg::CORDIC_X0;
			y_q    <= '0;
			z_q    <= $signed({{2{a_fold[31]}}, a_fold});
			flip_q <= fold;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (fin_q) begin
			c_q <= xr;
			s_q <= yr;
		end
	end

	assign rsp.done = done_q;
	assign rsp.c    = c_q;
	assign rsp.s    = s_q;

endmodule

[hdl/wheel_imu_dead_reckoning.sv]
// ----------------------------------------------------------------------------
// wheel_imu_dead_reckoning
// planar dead reckoning from wheel rates, imu yaw rate and time ticks
// ----------------------------------------------------------------------------
// One word at a time. An imu word only sets the yaw rate and leaves the block
// idle; a wheel word runs one cordic pass, then two multiplies on the
// two-bit-per-cycle serial multiplier, and goes back to idle; a tick word runs
// four serial multiplies and a cordic pass, then loads the output register and
// returns to idle; it is held before the load while the previous
// result still waits. The result sits in an output register and the next word
// is taken while it waits.
module wheel_imu_dead_reckoning (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] right_wheel_rate,
	input  logic signed [15:0] left_wheel_rate,
	input  logic signed [15:0] imu_yaw_rate,
	input  logic [15:0]        elapsed_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position_x,
	output logic signed [31:0] position_y,
	output logic [31:0]        heading_angle,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	output logic signed [31:0] velocity_x,
	output logic signed [31:0] velocity_y,
	output logic signed [15:0] yaw_rate_out
);

	typedef enum logic [3:0] {
		S_IDLE, S_W_COR, S_W_MX, S_W_MY,
		S_T_MX, S_T_MY, S_T_MH1, S_T_MH2, S_T_COR, S_T_OUT
	} state_t;

	state_t             state_q;
	logic [15:0]        radius_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic [31:0]        heading_q;
	logic signed [31:0] vel_x_q;
	logic signed [31:0] vel_y_q;
	logic signed [15:0] yaw_q;
	logic signed [33:0] spd_q;
	logic [15:0]        dt_q;
	logic signed [15:0] cs_q;
	logic               busy_q;
	logic               ovalid_q;
	wdr_pkg::mul_req_t  mreq;
	wdr_pkg::mul_rsp_t  mrsp;
	wdr_pkg::cor_req_t  creq;
	wdr_pkg::cor_rsp_t  crsp;
	logic               accept;
	logic               load_out;
	logic signed [16:0] sum;
	logic signed [79:0] rnd24;
	logic signed [79:0] rnd16;
	logic signed [79:0] rnd28;
	logic signed [33:0] psum;

	wdr_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	wdr_cordic u_cor (.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	function automatic logic signed [79:0] rshift(input logic signed [79:0] v,
			input int s);
		logic [79:0] m;
		m = v[79] ? 80'(-v) : 80'(v);
		m = (m + (80'd1 << (s - 1))) >> s;
		return v[79] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
		return 32'(v);
	endfunction

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_T_OUT) && (!ovalid_q || out_ready);
	assign sum      = 17'(right_wheel_rate) + 17'(left_wheel_rate);
	assign rnd24    = rshift(mrsp.p, 24);
	assign rnd16    = rshift(mrsp.p, 16);
	assign rnd28    = rshift(mrsp.p, 28);

	always_comb begin
		mreq = '0;
		creq = '0;
		psum = '0;
		if (accept && wdr_pkg::opcode_t'(opcode) == wdr_pkg::OP_WHEEL) begin
			creq.start = 1'b1;
			creq.angle = heading_q;
		end
		if (accept && wdr_pkg::opcode_t'(opcode) == wdr_pkg::OP_TICK) begin
			mreq.start = 1'b1;
			mreq.a     = 48'(vel_x_q);
			mreq.b     = 32'(elapsed_time);
		end
		case (state_q)
			S_W_COR: if (crsp.done) begin
				mreq.start = 1'b1;
				mreq.a     = 48'(spd_q);
				mreq.b     = 32'(crsp.c);
			end
			S_W_MX: if (mrsp.done) begin
				mreq.start = 1'b1;
				mreq.a     = 48'(spd_q);
				mreq.b     = 32'(cs_q);
			end
			S_T_MX: begin
				psum = 34'(pos_x_q) + 34'(rnd16);
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = 48'(vel_y_q);
					mreq.b     = 32'(dt_q);
				end
			end
			S_T_MY: begin
				psum = 34'(pos_y_q) + 34'(rnd16);
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = 48'(yaw_q);
					mreq.b     = 32'(dt_q);
				end
			end
			S_T_MH1: if (mrsp.done) begin
				mreq.start = 1'b1;
				mreq.a     = 48'(mrsp.p);
				mreq.b     = 32'(wdr_pkg::BAM_PER_RAD);
			end
			S_T_MH2: if (mrsp.done) begin
				creq.start = 1'b1;
				creq.angle = (heading_q + 32'(rnd28)) >> 1;
			end
			default: ;
		endcase
	end

	// the wheel sin product reuses the multiplier with a sign-extended sin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			busy_q        <= 1'b0;
			ovalid_q      <= 1'b0;
			radius_q      <= wdr_pkg::RADIUS_RESET;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			heading_q     <= '0;
			vel_x_q       <= '0;
			vel_y_q       <= '0;
			yaw_q         <= '0;
			position_x    <= '0;
			position_y    <= '0;
			heading_angle <= '0;
			quat_z        <= '0;
			quat_w        <= '0;
			velocity_x    <= '0;
			velocity_y    <= '0;
			yaw_rate_out  <= '0;
		end else begin
			if (cfg_we) radius_q <= cfg_wdata;
			if (load_out) begin
				ovalid_q      <= 1'b1;
				position_x    <= pos_x_q;
				position_y    <= pos_y_q;
				heading_angle <= heading_q;
				quat_z        <= crsp.s;
				quat_w        <= crsp.c;
				velocity_x    <= vel_x_q;
				velocity_y    <= vel_y_q;
				yaw_rate_out  <= yaw_q;
			end else if (out_valid && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (accept) begin
					case (wdr_pkg::opcode_t'(opcode))
						wdr_pkg::OP_WHEEL: begin
							busy_q  <= 1'b1;
							state_q <= S_W_COR;
						end
						wdr_pkg::OP_IMU: yaw_q <= imu_yaw_rate;
						wdr_pkg::OP_TICK: begin
							busy_q  <= 1'b1;
							state_q <= S_T_MX;
						end
						default: ;
					endcase
				end
				S_W_COR: if (crsp.done) state_q <= S_W_MX;
				S_W_MX: if (mrsp.done) begin
					vel_x_q <= 32'(rnd24);
					state_q <= S_W_MY;
				end
				S_W_MY: if (mrsp.done) begin
					vel_y_q <= 32'(rnd24);
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				S_T_MX: if (mrsp.done) begin
					pos_x_q <= sat32(psum);
					state_q <= S_T_MY;
				end
				S_T_MY: if (mrsp.done) begin
					pos_y_q <= sat32(psum);
					state_q <= S_T_MH1;
				end
				S_T_MH1: if (mrsp.done) state_q <= S_T_MH2;
				S_T_MH2: if (mrsp.done) begin
					heading_q <= heading_q + 32'(rnd28);
					state_q   <= S_T_COR;
				end
				S_T_COR: if (crsp.done) state_q <= S_T_OUT;
				S_T_OUT: if (load_out) begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			spd_q <= $signed({1'b0, radius_q}) * sum;
			dt_q  <= elapsed_time;
		end
		if (state_q == S_W_COR && crsp.done) cs_q <= crsp.s;
	end

	assign out_valid = ovalid_q;

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid);
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({position_x, position_y, heading_angle,
			quat_z, quat_w, velocity_x, velocity_y, yaw_rate_out}));
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) != busy_q);
`endif

endmodule

[tb/wdr_checker.sv]
// ----------------------------------------------------------------------------
// wdr_checker
// Watches the configuration port and both word channels of the dead-reckoning
// block. It keeps its own copy of the pose, velocity and yaw-rate state, and
// predicts the pose word that each tick word produces. It then compares every
// output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module wdr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] right_wheel_rate,
	input  logic signed [15:0] left_wheel_rate,
	input  logic signed [15:0] imu_yaw_rate,
	input  logic [15:0]        elapsed_time,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] position_x,
	input  logic signed [31:0] position_y,
	input  logic [31:0]        heading_angle,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [31:0] velocity_x,
	input  logic signed [31:0] velocity_y,
	input  logic signed [15:0] yaw_rate_out,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] hd;
		logic [15:0] qz;
		logic [15:0] qw;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [15:0] yr;
	} pose_t;

	localparam longint ANGLE_STEP [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	pose_t       pose_q[$];
	logic [15:0] radius;
	longint      px, py, vx, vy, yr;
	logic [31:0] hd;

	function automatic longint round_sh(longint v, int s);
		logic [63:0] m;
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
		logic [31:0] a;
		logic [31:0] t;
		logic        flip;
		longint      x, y, z, dx, dy;
		a = ang;
		t = a - 32'h4000_0000;
		flip = (t < 32'h8000_0000);
		if (flip)
			a = a + 32'h8000_0000;
		z = longint'(signed'(a));
		x = wdr_pkg::CORDIC_X0;
		y = 0;
		for (int i = 0; i < wdr_pkg::CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ANGLE_STEP[i];
			end else begin
				x += dx; y -= dy; z += ANGLE_STEP[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = sat(round_sh(x, 15), -32768, 32767);
		s = sat(round_sh(y, 15), -32768, 32767);
	endtask

	task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
		if (a !== e) begin
			errors++;
			$display("%0t ns: %s expected %h, got %h", $time, nm, e, a);
		end
	endtask

	task automatic take_word();
		longint spd, c, s, dt, dh;
		pose_t  p;
		case (wdr_pkg::opcode_t'(opcode))
			wdr_pkg::OP_WHEEL: begin
				spd = longint'(radius) *
					(longint'(right_wheel_rate) + longint'(left_wheel_rate));
				sin_cos(hd, c, s);
				vx = round_sh(spd * c, 24);
				vy = round_sh(spd * s, 24);
			end
			wdr_pkg::OP_IMU: yr = longint'(imu_yaw_rate);
			wdr_pkg::OP_TICK: begin
				dt = longint'(elapsed_time);
				px = sat(px + round_sh(vx * dt, 16), -64'sd2147483648, 64'sd2147483647);
				py = sat(py + round_sh(vy * dt, 16), -64'sd2147483648, 64'sd2147483647);
				dh = round_sh(yr * dt * longint'(wdr_pkg::BAM_PER_RAD), 28);
				hd = hd + dh[31:0];
				sin_cos({1'b0, hd[31:1]}, c, s);
				p.px = px[31:0];
				p.py = py[31:0];
				p.hd = hd;
				p.qz = s[15:0];
				p.qw = c[15:0];
				p.vx = vx[31:0];
				p.vy = vy[31:0];
				p.yr = yr[15:0];
				pose_q.push_back(p);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius = wdr_pkg::RADIUS_RESET;
			px = 0; py = 0; vx = 0; vy = 0; yr = 0; hd = '0;
			pose_q.delete();
			errors = 0;
		end else begin
			if (cfg_we)
				radius = cfg_wdata;
			if (in_valid && in_ready)
				take_word();
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					errors++;
					$display("%0t ns: output word with none expected, x %h", $time,
						position_x);
				end else begin
					check_field("position_x", pose_q[0].px, position_x);
					check_field("position_y", pose_q[0].py, position_y);
					check_field("heading_angle", pose_q[0].hd, heading_angle);
					check_field("quat_z", {16'd0, pose_q[0].qz}, {16'd0, quat_z});
					check_field("quat_w", {16'd0, pose_q[0].qw}, {16'd0, quat_w});
					check_field("velocity_x", pose_q[0].vx, velocity_x);
					check_field("velocity_y", pose_q[0].vy, velocity_y);
					check_field("yaw_rate_out", {16'd0, pose_q[0].yr}, {16'd0, yaw_rate_out});
					void'(pose_q.pop_front());
				end
			end
		end
		pending = pose_q.size();
	end

endmodule

[tb/tb_wheel_imu_dead_reckoning.sv]
// ----------------------------------------------------------------------------
// tb_wheel_imu_dead_reckoning
// Drives wheel, imu and tick words into the dead-reckoning block under several
// wheel radius settings: a saturation sweep, directed corner words, then random
// words in bursts. The output side stalls, and once it holds off for a long
// stretch. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_wheel_imu_dead_reckoning;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 300;
	localparam int LONG_HOLD = 3000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic signed [15:0] right_wheel_rate;
	logic signed [15:0] left_wheel_rate;
	logic signed [15:0] imu_yaw_rate;
	logic [15:0]        elapsed_time;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic [31:0]        heading_angle;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic signed [15:0] yaw_rate_out;
	int                 errors;
	int                 pending;

	int words_sent;
	int poses_seen;
	int idle_cycles;
	int burst_left;
	int radius_writes;
	bit gapless;

	wheel_imu_dead_reckoning dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.right_wheel_rate(right_wheel_rate), .left_wheel_rate(left_wheel_rate),
		.imu_yaw_rate(imu_yaw_rate), .elapsed_time(elapsed_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.position_x(position_x), .position_y(position_y),
		.heading_angle(heading_angle), .quat_z(quat_z), .quat_w(quat_w),
		.velocity_x(velocity_x), .velocity_y(velocity_y), .yaw_rate_out(yaw_rate_out)
	);

	wdr_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.right_wheel_rate(right_wheel_rate), .left_wheel_rate(left_wheel_rate),
		.imu_yaw_rate(imu_yaw_rate), .elapsed_time(elapsed_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.position_x(position_x), .position_y(position_y),
		.heading_angle(heading_angle), .quat_z(quat_z), .quat_w(quat_w),
		.velocity_x(velocity_x), .velocity_y(velocity_y), .yaw_rate_out(yaw_rate_out),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (out_valid && out_ready)
			poses_seen <= poses_seen + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("wheel_imu_dead_reckoning: mismatch");
			$finish;
		end
	end

	// output stall pattern, with one long hold-off
	initial begin : rx_stall
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && poses_seen >= 40) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			if ($urandom_range(0, 3) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send_word(input wdr_pkg::opcode_t op, input logic [15:0] r,
		input logic [15:0] l, input logic [15:0] y, input logic [15:0] dt);
		in_valid <= 1'b1;
		opcode <= op;
		right_wheel_rate <= r;
		left_wheel_rate <= l;
		imu_yaw_rate <= y;
		elapsed_time <= dt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if (!gapless) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic send_random();
		int pick;
		wdr_pkg::opcode_t op;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = wdr_pkg::OP_WHEEL;
		else if (pick < 55)
			op = wdr_pkg::OP_IMU;
		else if (pick < 96)
			op = wdr_pkg::OP_TICK;
		else
			op = wdr_pkg::OP_NONE;
		send_word(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic set_radius(input logic [15:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_writes++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = wdr_pkg::OP_NONE;
		right_wheel_rate = '0;
		left_wheel_rate = '0;
		imu_yaw_rate = '0;
		elapsed_time = '0;
		words_sent = 0;
		poses_seen = 0;
		idle_cycles = 0;
		burst_left = 0;
		radius_writes = 0;
		gapless = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation sweep at full radius and full wheel rate, heading zero
		set_radius(16'hffff);
		send_word(wdr_pkg::OP_WHEEL, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
		repeat (262) send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'hffff);
		// turn to about minus a quarter turn, then drive y negative
		send_word(wdr_pkg::OP_IMU, 16'h0, 16'h0, 16'h8000, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'd12868);
		send_word(wdr_pkg::OP_IMU, 16'h0, 16'h0, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_WHEEL, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
		repeat (262) send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'hffff);
		gapless = 1'b0;

		// corner words at the default radius
		set_radius(wdr_pkg::RADIUS_RESET);
		send_word(wdr_pkg::OP_IMU, 16'h0, 16'h0, 16'h7fff, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'hffff);
		send_word(wdr_pkg::OP_WHEEL, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_WHEEL, 16'h8000, 16'h8000, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'hffff);
		send_word(wdr_pkg::OP_IMU, 16'h0, 16'h0, 16'h8000, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'hffff);
		send_word(wdr_pkg::OP_WHEEL, 16'h7fff, 16'h8000, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h1);
		send_word(wdr_pkg::OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h8000);
		send_word(wdr_pkg::OP_IMU, 16'h0, 16'h0, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_WHEEL, 16'h0, 16'h0, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'hffff);
		send_word(wdr_pkg::OP_WHEEL, 16'h0001, 16'h0000, 16'h0, 16'h0);
		send_word(wdr_pkg::OP_TICK, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

		set_radius(16'h0);
		repeat (85) send_random();
		set_radius(16'($urandom));
		repeat (85) send_random();
		set_radius(16'hffff);
		repeat (85) send_random();
		set_radius(wdr_pkg::RADIUS_RESET);
		repeat (85) send_random();

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d words, checked %0d pose words over %0d radius settings",
			words_sent, poses_seen, radius_writes);
		$display("covered position saturation, heading wrap and unused opcode");
		if (errors == 0)
			$display("wheel_imu_dead_reckoning: match");
		else
			$display("wheel_imu_dead_reckoning: mismatch");
		$finish;
	end

endmodule
